/* src/i2cbs_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Types, command codes and phase constants shared by the I2C bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

    // Command codes as they arrive in the func field
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam int PHASE_W = 5;

    // Index of the final phase of each command's run
    localparam logic [PHASE_W-1:0] LAST_START = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_STOP  = 5'd3;
    localparam logic [PHASE_W-1:0] LAST_BYTE  = 5'd18;

    // Phases after the eight bit clocks of a byte transfer
    localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 5'd17;
    localparam logic [PHASE_W-1:0] PH_TAIL     = 5'd18;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] operand;
        logic [7:0] target_bits;
    } cmd_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driven;
        logic [7:0] rx_byte;
        logic       last;
    } phase_word_t;

    // Classified command as held in the queue
    typedef struct packed {
        cmd_kind_t          kind;
        logic [PHASE_W-1:0] last_idx;
        logic               ack_bit;
        logic [7:0]         data;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } cmdq_port_t;

endpackage : i2cbs_pkg

`default_nettype wire

/* src/i2c_master_bit_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master line-phase sequencer: start, stop, write byte and read byte.
// ----------------------------------------------------------------------------
// Usage
//   cmd channel (cmd_valid/cmd_ready/cmd): one command word per handshake,
//   func selects start, stop, write byte or read byte. A write sends operand
//   MSB first then releases data for an unchecked acknowledge clock; a read
//   samples target_bits MSB first and answers ACK when operand is nonzero.
//   phase channel (phase_valid/phase_ready/phase): one line phase per word,
//   giving clock level, data level and data drive; last marks the final
//   phase of a command, and rx_byte carries a read's byte on that phase.
// Timing
//   A start gives 3 phases, a stop 4, a write or read 19. The sequencer
//   emits one phase per cycle unless phase_ready holds it, and a queued
//   command's phases follow the previous run without a gap. When idle, an
//   accepted command is written into the queue, then its first phase into
//   the output register. Commands wait in a queue of QUEUE_DEPTH words,
//   and cmd_ready drops only when that queue is full.
// Reset and stall
//   Reset empties the queue, drops the output valid and sets the data
//   latch high. While phase_ready is low the current phase is held and the
//   sequencer stops; the queue keeps taking commands until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core #(
    parameter int QUEUE_DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cmd_valid,
    output logic                    cmd_ready,
    input  i2cbs_pkg::cmd_word_t    cmd,
    output logic                    phase_valid,
    input  wire                     phase_ready,
    output i2cbs_pkg::phase_word_t  phase
);

    // queue traffic between the classifier and the sequencer
    i2cbs_pkg::cmdq_port_t q_wr;
    i2cbs_pkg::cmdq_port_t q_rd;
    logic                  q_full;
    logic                  q_pop;

    // classify commands on the way in
    i2cbs_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    // hold commands so either side can stall on its own
    i2cbs_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    // expand each command into its run of line phases
    i2cbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rd        (q_rd),
        .q_pop       (q_pop),
        .phase_valid (phase_valid),
        .phase_ready (phase_ready),
        .phase       (phase)
    );

endmodule : i2c_master_bit_sequencer_core

`default_nettype wire

/* src/i2cbs_front.sv */
// ----------------------------------------------------------------------------
// i2cbs_front
// Accepts command words and classifies them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_front (
    input  wire                    cmd_valid,
    output logic                   cmd_ready,
    input  i2cbs_pkg::cmd_word_t   cmd,
    input  wire                    q_full,
    output i2cbs_pkg::cmdq_port_t  q_wr
);

    i2cbs_pkg::cmd_entry_t entry;

    always_comb
    begin
        entry         = '0;
        entry.ack_bit = (cmd.operand != 8'd0) ? 1'b0 : 1'b1;
        entry.data    = cmd.operand;
        case (cmd.func)
            i2cbs_pkg::FUNC_START:
            begin
                entry.kind     = i2cbs_pkg::CMD_START;
                entry.last_idx = i2cbs_pkg::LAST_START;
            end
            i2cbs_pkg::FUNC_STOP:
            begin
                entry.kind     = i2cbs_pkg::CMD_STOP;
                entry.last_idx = i2cbs_pkg::LAST_STOP;
            end
            i2cbs_pkg::FUNC_WRITE:
            begin
                entry.kind     = i2cbs_pkg::CMD_WRITE;
                entry.last_idx = i2cbs_pkg::LAST_BYTE;
            end
            default:
            begin
                // read: carry the target's levels instead of the operand
                entry.kind     = i2cbs_pkg::CMD_READ;
                entry.last_idx = i2cbs_pkg::LAST_BYTE;
                entry.data     = cmd.target_bits;
            end
        endcase
    end

    assign cmd_ready  = !q_full;
    assign q_wr.valid = cmd_valid && !q_full;
    assign q_wr.entry = entry;

endmodule : i2cbs_front

`default_nettype wire

/* src/i2cbs_cmdq.sv */
// ----------------------------------------------------------------------------
// i2cbs_cmdq
// Short FIFO of classified commands between the front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_cmdq #(
    parameter int DEPTH = i2cbs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  i2cbs_pkg::cmdq_port_t  q_wr,
    output logic                   q_full,
    output i2cbs_pkg::cmdq_port_t  q_rd,
    input  wire                    q_pop
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cbs_pkg::cmd_entry_t slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push, pop;

    assign q_full     = (count_reg == CNT_W'(DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.entry = slot_reg[rd_ptr_reg];

    assign push = q_wr.valid && !q_full;
    assign pop  = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

endmodule : i2cbs_cmdq

`default_nettype wire

/* src/i2cbs_back.sv */
// ----------------------------------------------------------------------------
// i2cbs_back
// Phase sequencer: expands queued commands into line phases, one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  i2cbs_pkg::cmdq_port_t       q_rd,
    output logic                        q_pop,
    output logic                        phase_valid,
    input  wire                         phase_ready,
    output i2cbs_pkg::phase_word_t      phase
);

    localparam int PW = i2cbs_pkg::PHASE_W;

    function automatic i2cbs_pkg::phase_word_t phase_of(
        i2cbs_pkg::cmd_entry_t e,
        logic [PW-1:0]         p,
        logic                  latch
    );
        i2cbs_pkg::phase_word_t o;
        logic [2:0]             bi;
        o      = '0;
        bi     = p[0] ? ~p[3:1] : ~(p[3:1] - 3'd1);
        o.last = (p == e.last_idx);
        case (e.kind)
            i2cbs_pkg::CMD_START:
            begin
                o.sda_driven = 1'b1;
                o.scl_level  = (p != i2cbs_pkg::LAST_START);
                o.sda_level  = (p == '0);
            end
            i2cbs_pkg::CMD_STOP:
            begin
                o.sda_driven = 1'b1;
                o.scl_level  = p[1];
                o.sda_level  = (p == '0) ? latch : (p == i2cbs_pkg::LAST_STOP);
            end
            i2cbs_pkg::CMD_WRITE:
            begin
                if (!p[4])
                begin
                    // low phase repeats the previous bit, high phase shows the next
                    o.scl_level  = p[0];
                    o.sda_driven = 1'b1;
                    o.sda_level  = (p[0] || p[3:1] != 3'd0) ? e.data[bi] : 1'b0;
                end
                else
                begin
                    o.scl_level  = (p != i2cbs_pkg::PH_ACK_LOW);
                    o.sda_driven = (p == i2cbs_pkg::PH_TAIL);
                end
            end
            default:
            begin
                if (!p[4])
                begin
                    o.scl_level = p[0];
                end
                else
                begin
                    o.scl_level  = (p == i2cbs_pkg::PH_ACK_HIGH);
                    o.sda_driven = (p != i2cbs_pkg::PH_TAIL);
                    o.sda_level  = (p == i2cbs_pkg::PH_ACK_HIGH) && e.ack_bit;
                    o.rx_byte    = (p == i2cbs_pkg::PH_TAIL) ? e.data : 8'd0;
                end
            end
        endcase
        return o;
    endfunction

    logic                   busy_reg,      busy_next;
    logic [PW-1:0]          phase_idx_reg, phase_idx_next;
    i2cbs_pkg::cmd_entry_t  cmd_reg,       cmd_next;
    logic                   latch_reg,     latch_next;
    logic                   out_valid_reg, out_valid_next;
    i2cbs_pkg::phase_word_t out_reg,       out_next;

    logic                   advance, emit;
    i2cbs_pkg::cmd_entry_t  sel_entry;
    logic [PW-1:0]          sel_phase;
    i2cbs_pkg::phase_word_t cur;

    assign advance   = !out_valid_reg || phase_ready;
    assign emit      = advance && (busy_reg || q_rd.valid);
    assign q_pop     = advance && !busy_reg && q_rd.valid;
    assign sel_entry = busy_reg ? cmd_reg : q_rd.entry;
    assign sel_phase = busy_reg ? phase_idx_reg : '0;
    assign cur       = phase_of(sel_entry, sel_phase, latch_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        phase_idx_next = phase_idx_reg;
        cmd_next       = cmd_reg;
        latch_next     = latch_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !phase_ready;
        if (q_pop)
        begin
            cmd_next = q_rd.entry;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = cur;
            busy_next      = !cur.last;
            phase_idx_next = sel_phase + 1'b1;
            if (cur.last)
            begin
                // data latch is left high only by a stop
                latch_next = (sel_entry.kind == i2cbs_pkg::CMD_STOP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_idx_reg <= '0;
            latch_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_idx_reg <= phase_idx_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign phase_valid = out_valid_reg;
    assign phase       = out_reg;

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_idx_reg != '0) && (phase_idx_reg <= cmd_reg.last_idx))
        else $error("sequencer busy outside a command run");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg && q_rd.valid)
        else $error("command popped while a run is in progress");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.sda_driven |-> !out_reg.sda_level)
        else $error("released data line shows a driven level");

    a_rx_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> (out_reg.rx_byte == 8'd0))
        else $error("received byte shown before the final phase");

    a_stop_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        emit && cur.last && (sel_entry.kind == i2cbs_pkg::CMD_STOP) |=> latch_reg)
        else $error("data latch not high after a stop");

endmodule : i2cbs_back

`default_nettype wire
